// ===== sv/aabm_pkg.sv =====
// ----------------------------------------------------------------------------
// aabm_pkg
// Shared types, command codes and the Booth multiply function for the
// accumulator ALU.
// ----------------------------------------------------------------------------
package aabm_pkg;

  localparam int DATA_W = 8;
  localparam int CMD_W  = 5;

  // alu command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_WACC = 5'h09,
    CMD_RACC = 5'h0B,
    CMD_BRLT = 5'h11,
    CMD_BRGT = 5'h12,
    CMD_BRNE = 5'h13,
    CMD_BRE  = 5'h14,
    CMD_SHR  = 5'h15,
    CMD_SHL  = 5'h16,
    CMD_XOR  = 5'h17,
    CMD_NOT  = 5'h18,
    CMD_OR   = 5'h19,
    CMD_AND  = 5'h1A,
    CMD_MUL  = 5'h1B,
    CMD_SUB  = 5'h1D,
    CMD_ADD  = 5'h1E
  } cmd_t;

  // input request
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] operand;
  } aabm_in_t;

  // result request
  typedef struct packed {
    logic [DATA_W-1:0] acc_value;
    logic [DATA_W-1:0] bus_value;
    logic              zero_flag;
    logic              carry_flag;
    logic              sign_flag;
    logic              overflow_flag;
    logic              bad_command;
  } aabm_out_t;

  // radix-2 booth recurrence with a data-width partial register
  function automatic logic [2*DATA_W-1:0] booth_mul(input logic [DATA_W-1:0] mplr,
                                                    input logic [DATA_W-1:0] mcnd);
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] lo;
    logic              prev;
    hi   = '0;
    lo   = mplr;
    prev = 1'b0;
    for (int i = 0; i < DATA_W; i++) begin
      case ({lo[0], prev})
        2'b01:   hi = hi + mcnd;
        2'b10:   hi = hi - mcnd;
        default: hi = hi;
      endcase
      prev = lo[0];
      lo   = {hi[0], lo[DATA_W-1:1]};
      hi   = {hi[DATA_W-1], hi[DATA_W-1:1]};
    end
    return {hi, lo};
  endfunction

endpackage

// ===== sv/aabm_alu.sv =====
// ----------------------------------------------------------------------------
// aabm_alu
// Combinational datapath: one command against the accumulator, giving the
// new accumulator, bus byte and flags.
// ----------------------------------------------------------------------------
module aabm_alu (
  input  aabm_pkg::aabm_in_t           req,
  input  logic [aabm_pkg::DATA_W-1:0]  acc,
  output aabm_pkg::aabm_out_t          res
);
  import aabm_pkg::*;

  logic [2*DATA_W-1:0] prod;
  logic [DATA_W-1:0]   opd;
  logic [DATA_W-1:0]   diff;
  logic                lt;
  logic                big_shift;

  assign opd       = req.operand;
  assign prod      = booth_mul(acc, opd);
  assign diff      = acc - opd;
  assign lt        = (acc < opd);
  assign big_shift = (opd >= DATA_W'(DATA_W));

  // command decode and flag generation
  always_comb begin
    res               = '0;
    res.acc_value     = acc;
    res.bus_value     = opd;
    case (req.cmd)
      CMD_ADD:  res.acc_value = acc + opd;
      CMD_SUB:  res.acc_value = diff;
      CMD_MUL:  res.acc_value = prod[DATA_W-1:0];
      CMD_AND:  res.acc_value = acc & opd;
      CMD_OR:   res.acc_value = acc | opd;
      CMD_NOT:  res.acc_value = ~acc;
      CMD_XOR:  res.acc_value = acc ^ opd;
      CMD_SHR:  res.acc_value = big_shift ? '0 : (acc >> opd);
      CMD_SHL:  res.acc_value = big_shift ? '0 : (acc << opd);
      CMD_BRLT, CMD_BRGT: begin
        res.acc_value = diff;
        res.sign_flag = lt;
      end
      CMD_BRNE, CMD_BRE: res.acc_value = diff;
      CMD_WACC: res.acc_value = opd;
      CMD_RACC: res.bus_value = acc;
      default:  res.bad_command = 1'b1;
    endcase

    // flags follow the full product for multiply, the result otherwise
    if (req.cmd == CMD_MUL) begin
      res.zero_flag  = (prod == '0);
      res.carry_flag = (prod[2*DATA_W-1:DATA_W] != '0);
    end else begin
      res.zero_flag  = (res.acc_value == '0);
      res.carry_flag = res.sign_flag;
    end
    res.overflow_flag = res.carry_flag;
  end

endmodule

// ===== sv/accumulator_alu_booth_multiply.sv =====
// ----------------------------------------------------------------------------
// accumulator_alu_booth_multiply
// Accumulator ALU, signed Booth multiply, one command per clock if unstalled.
// ----------------------------------------------------------------------------
// The block takes one command per clock while the result side is not
// stalled and returns one result for each. A request is captured in an
// input register, goes through the combinational ALU (the 8-step Booth
// multiply is the longest path) and lands in the result register together
// with the accumulator update. Back-to-back commands see the accumulator
// left by the command before them. When the result is stalled the input
// register still holds one more request before in_stall rises.
module accumulator_alu_booth_multiply (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  aabm_pkg::aabm_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output aabm_pkg::aabm_out_t  out_data
);
  import aabm_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  aabm_in_t          s1_data_r;
  logic              out_valid_r, out_valid_nxt;
  aabm_out_t         out_data_r;
  logic [DATA_W-1:0] acc_r;
  aabm_out_t         alu_res;
  logic              advance;
  logic              accept;

  // handshake control
  assign advance       = !out_valid_r || !out_stall;
  assign in_stall      = s1_valid_r && !advance;
  assign accept        = in_valid && !in_stall;
  assign s1_valid_nxt  = accept || (s1_valid_r && !advance);
  assign out_valid_nxt = advance ? s1_valid_r : out_valid_r;

  aabm_alu u_alu (
    .req (s1_data_r),
    .acc (acc_r),
    .res (alu_res)
  );

  // control and accumulator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance && s1_valid_r) begin
        acc_r <= alu_res.acc_value;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data_r <= in_data;
    end
    if (advance && s1_valid_r) begin
      out_data_r <= alu_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/aabm_checker.sv =====
// ----------------------------------------------------------------------------
// aabm_checker
// Port-level checks for the accumulator ALU, bound to the top level.
// ----------------------------------------------------------------------------
module aabm_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input aabm_pkg::aabm_in_t   in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input aabm_pkg::aabm_out_t  out_data
);
  import aabm_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // the input side only backs up behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side free");

  // carry and overflow agree, sign implies both
  a_flag_tie: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.carry_flag == out_data.overflow_flag) &&
                  (!out_data.sign_flag || out_data.carry_flag))
    else $error("inconsistent carry, overflow and sign flags");

  // without a wide flag result the zero flag follows the accumulator
  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.carry_flag |->
      out_data.zero_flag == (out_data.acc_value == '0))
    else $error("zero flag does not match accumulator");

  // an unknown command raises no arithmetic flags
  a_bad_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_command |->
      !out_data.carry_flag && !out_data.sign_flag)
    else $error("flags set on unknown command");

endmodule

bind accumulator_alu_booth_multiply aabm_checker u_aabm_checker (.*);
